// ===== sv/ahcfd_pkg.sv =====
// ============================================================================
// ahcfd_pkg - shared types and constants of the ASCII hex frame decoder
// Character codes, field positions, the hex nibble decoder and the message
// record that travels from the decode core to the output register.
// ============================================================================
package ahcfd_pkg;

    localparam logic [7:0] CHR_STX    = 8'h02;
    localparam logic [7:0] CHR_ETX    = 8'h03;
    localparam int unsigned DATA_START = 11;
    localparam int unsigned MAX_DLC    = 8;
    localparam int unsigned FRAME_OVERHEAD = 16;

    typedef struct packed {
        logic        extended_id;
        logic [31:0] message_id;
        logic [3:0]  data_length;
        logic [63:0] payload;
        logic [15:0] frame_crc;
    } t_message;

    // Characters that are not hex digits decode as zero.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c inside {[8'h30:8'h39]}) begin
                d = c - 8'h30;
            end else if (c inside {[8'h61:8'h66]}) begin
                d = c - 8'h61 + 8'd10;
            end else if (c inside {[8'h41:8'h46]}) begin
                d = c - 8'h41 + 8'd10;
            end
            return d[3:0];
        end
    endfunction

endpackage

// ===== sv/ahcfd_if.sv =====
// ============================================================================
// ahcfd_in_if / ahcfd_out_if - request channels of the frame decoder
// Valid/ready channels: one carries received bytes, the other messages.
// ============================================================================
interface ahcfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       read_error;

    modport source (output valid, output rx_byte, output read_error, input ready);
    modport sink   (input valid, input rx_byte, input read_error, output ready);
endinterface

interface ahcfd_out_if;
    logic        valid;
    logic        ready;
    logic        extended_id;
    logic [31:0] message_id;
    logic [3:0]  data_length;
    logic [63:0] payload;
    logic [15:0] frame_crc;

    modport source (output valid, output extended_id, output message_id,
                    output data_length, output payload, output frame_crc,
                    input ready);
    modport sink   (input valid, input extended_id, input message_id,
                    input data_length, input payload, input frame_crc,
                    output ready);
endinterface

// ===== sv/ahcfd_core.sv =====
// ============================================================================
// ahcfd_core - frame state and field accumulators
// Advances the frame collection by one byte per step and flags a complete,
// well-formed message.
// ============================================================================
module ahcfd_core #(
    parameter int unsigned FRAME_BUFFER_BYTES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_err,
    output logic                  o_msg_valid,
    output ahcfd_pkg::t_message   o_msg
);
    import ahcfd_pkg::*;

    localparam int unsigned PW = $clog2(FRAME_BUFFER_BYTES + 1);

    logic          r_in_frame, n_in_frame;
    logic [PW-1:0] r_pos,      n_pos;
    logic [7:0]    r_flag,     n_flag;
    logic [31:0]   r_id,       n_id;
    logic [63:0]   r_payload,  n_payload;
    logic [15:0]   r_crc,      n_crc;

    logic [3:0]    nib;
    logic [3:0]    dlc_cur;
    logic [3:0]    dlc_new;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] data_end;
    logic [PW-1:0] data_off;

    always_comb begin
        nib      = nibble_of(i_byte);
        dlc_cur  = r_flag[3:0];
        data_end = PW'(DATA_START) + PW'({dlc_cur, 1'b0});
        data_off = r_pos - PW'(DATA_START);
        pos_next = r_pos + PW'(1);

        n_in_frame  = r_in_frame;
        n_pos       = r_pos;
        n_flag      = r_flag;
        n_id        = r_id;
        n_payload   = r_payload;
        n_crc       = r_crc;
        dlc_new     = r_flag[3:0];
        o_msg_valid = 1'b0;
        o_msg       = '0;

        if (i_err) begin
            n_in_frame = 1'b1;
            n_pos      = PW'(1);
            n_flag     = '0;
            n_id       = '0;
            n_payload  = '0;
            n_crc      = '0;
        end else if (!r_in_frame) begin
            if (i_byte == CHR_STX) begin
                n_in_frame = 1'b1;
                n_pos      = PW'(1);
                n_flag     = '0;
                n_id       = '0;
                n_payload  = '0;
                n_crc      = '0;
            end
        end else begin
            // Decode the character at its position in the frame.
            if (r_pos >= PW'(1) && r_pos <= PW'(2)) begin
                n_flag = {r_flag[3:0], nib};
            end else if (r_pos >= PW'(3) && r_pos <= PW'(10)) begin
                n_id = {r_id[27:0], nib};
            end else if (r_pos >= PW'(DATA_START) && r_pos < data_end) begin
                // Only the first eight data bytes have room; the high
                // nibble of each byte comes first.
                if (data_off < PW'(2 * MAX_DLC)) begin
                    n_payload[{data_off[3:0] ^ 4'd1, 2'b00} +: 4] =
                        r_payload[{data_off[3:0] ^ 4'd1, 2'b00} +: 4] | nib;
                end
            end else if (r_pos >= data_end && r_pos < data_end + PW'(4)) begin
                n_crc = {r_crc[11:0], nib};
            end
            n_pos   = pos_next;
            dlc_new = n_flag[3:0];

            if (pos_next >= PW'(FRAME_BUFFER_BYTES) || i_byte == CHR_STX) begin
                n_in_frame = 1'b1;
                n_pos      = PW'(1);
                n_flag     = '0;
                n_id       = '0;
                n_payload  = '0;
                n_crc      = '0;
            end else if (i_byte == CHR_ETX) begin
                if (dlc_new > 4'(MAX_DLC) ||
                    pos_next != PW'(FRAME_OVERHEAD) + PW'({dlc_new, 1'b0})) begin
                    n_in_frame = 1'b1;
                    n_pos      = PW'(1);
                end else begin
                    o_msg_valid       = 1'b1;
                    o_msg.extended_id = n_flag[4];
                    o_msg.message_id  = n_id;
                    o_msg.data_length = dlc_new;
                    o_msg.payload     = n_payload;
                    o_msg.frame_crc   = n_crc;
                    n_in_frame        = 1'b0;
                    n_pos             = '0;
                end
                n_flag    = '0;
                n_id      = '0;
                n_payload = '0;
                n_crc     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_flag     <= '0;
            r_id       <= '0;
            r_payload  <= '0;
            r_crc      <= '0;
        end else if (i_step) begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_flag     <= n_flag;
            r_id       <= n_id;
            r_payload  <= n_payload;
            r_crc      <= n_crc;
        end
    end

endmodule

// ===== sv/ascii_hex_can_frame_decoder.sv =====
// A byte accepted into the input register is decoded when the core steps; a
// message completed by an ETX byte is registered in the output register by
// that same step. Throughput: one byte per cycle while the output is not
// stalled, set by the single decode step between the input register and the
// output register. Synchronous active-low reset returns to waiting for STX,
// clears all accumulators and empties both registers.
// ============================================================================
// ascii_hex_can_frame_decoder - STX/ETX framed ASCII hex CAN message decoder
// Collects flag, identifier, data and CRC fields from a serial byte stream
// and emits one message per well-formed frame.
// ============================================================================
module ascii_hex_can_frame_decoder #(
    parameter int unsigned FRAME_BUFFER_BYTES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ahcfd_in_if.sink      i_in,
    ahcfd_out_if.source   o_out
);
    import ahcfd_pkg::*;

    // Input register. It holds one received byte (or read error) until the
    // decode core can take it. The core steps only when the output register
    // is empty or is being emptied in the same cycle, so a message produced
    // by the step always has somewhere to go.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_err;

    // Output register. A completed message waits here for its request to be
    // taken. While it waits, the input register can take one more byte, and
    // after that the input request stalls until the message is taken.
    logic       r_out_valid;
    t_message   r_out_msg;

    logic       out_free;
    logic       step;
    logic       msg_valid;
    t_message   msg;

    assign out_free   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
            r_in_err  <= i_in.read_error;
        end
    end

    // The core owns the frame state: the position counter and the flag,
    // identifier, payload and CRC accumulators.
    ahcfd_core #(
        .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_err       (r_in_err),
        .o_msg_valid (msg_valid),
        .o_msg       (msg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && msg_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && msg_valid && out_free) begin
            r_out_msg <= msg;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.extended_id = r_out_msg.extended_id;
    assign o_out.message_id  = r_out_msg.message_id;
    assign o_out.data_length = r_out_msg.data_length;
    assign o_out.payload     = r_out_msg.payload;
    assign o_out.frame_crc   = r_out_msg.frame_crc;

endmodule
